[hw/rtl/tsg_pkg.sv]
package tsg_pkg;

	// Number of voices mixed into one sample
	localparam int VOICE_COUNT = 3;

	// Field widths
	localparam int CMD_W    = 2;
	localparam int VOICE_W  = 2;
	localparam int STEP_W   = 19;
	localparam int LEN_W    = 20;
	localparam int IDX_W    = 7;
	localparam int VAL_W    = 13;
	localparam int SAMPLE_W = 15;
	localparam int DEG_W    = 9;
	localparam int LVL_W    = 5;

	// Mixer width: sum of all voices, doubled, minus the offset, signed
	localparam int MIX_W = $clog2(VOICE_COUNT * 4097) + 2;

	localparam int STORE_DEPTH = 91;

	localparam logic [STEP_W:0]   FULL_TURN  = (STEP_W+1)'(360000);
	localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(359999);
	localparam logic [VAL_W-1:0]  TOP_CODE   = VAL_W'(4096);
	localparam logic [VAL_W-1:0]  MID_CODE   = VAL_W'(12'h800);
	localparam logic [MIX_W-1:0]  MIX_OFFSET = MIX_W'(12 * 1024);

	localparam logic [DEG_W-1:0] DEG_QUARTER = DEG_W'(90);
	localparam logic [DEG_W-1:0] DEG_HALF    = DEG_W'(180);
	localparam logic [DEG_W-1:0] DEG_3QUART  = DEG_W'(270);
	localparam logic [DEG_W-1:0] DEG_FULL    = DEG_W'(360);

	// Envelope levels in sixteenths
	localparam logic [LVL_W-1:0] LVL_ATTACK  = LVL_W'(15);
	localparam logic [LVL_W-1:0] LVL_PEAK    = LVL_W'(16);
	localparam logic [LVL_W-1:0] LVL_SUSTAIN = LVL_W'(15);
	localparam logic [LVL_W-1:0] LVL_RELEASE = LVL_W'(10);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK = 2'd0,
		CMD_NOTE = 2'd1,
		CMD_LOAD = 2'd2
	} cmd_t;

	// Per-voice pipeline controls
	typedef struct packed {
		logic tick;
		logic note;
		logic load;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} voice_ctrl_t;

	// Reciprocal constants, exact over the ranges used
	localparam int                 D1000_S = 29;
	localparam logic [19:0]        D1000_K = 20'd536871;
	localparam int                 D10_IN_W = 24;
	localparam int                 D10_S = 28;
	localparam logic [24:0]        D10_K = 25'd26843546;

	// Millidegrees (below 360000) to whole degrees
	function automatic logic [DEG_W-1:0] div1000(input logic [STEP_W-1:0] p);
		logic [STEP_W+19:0] prod;
		prod = (STEP_W+20)'(p) * (STEP_W+20)'(D1000_K);
		return prod[D1000_S +: DEG_W];
	endfunction

	// Floor of x/10 for x up to 9 * (2^20 - 1)
	function automatic logic [LEN_W-1:0] div10(input logic [D10_IN_W-1:0] x);
		logic [D10_IN_W+24:0] prod;
		prod = (D10_IN_W+25)'(x) * (D10_IN_W+25)'(D10_K);
		return prod[D10_S +: LEN_W];
	endfunction

endpackage

[hw/rtl/tsg_voice.sv]
module tsg_voice (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tsg_pkg::voice_ctrl_t        ctrl,
	input  logic [tsg_pkg::STEP_W-1:0]  step,
	input  logic [tsg_pkg::LEN_W-1:0]   len,
	input  logic [tsg_pkg::IDX_W-1:0]   idx,
	input  logic [tsg_pkg::VAL_W-1:0]   val,
	output logic [tsg_pkg::VAL_W-1:0]   scaled
);
	import tsg_pkg::*;

	// Voice state
	logic [STEP_W-1:0] phase_acc_q;
	logic [STEP_W-1:0] active_step_q;
	logic [STEP_W-1:0] pending_step_q;
	logic [LEN_W-1:0]  remaining_len_q;
	logic              note_pending_q;
	logic [LEN_W-1:0]  attack_mark_q;
	logic [LEN_W-1:0]  decay_mark_q;
	logic [LEN_W-1:0]  sustain_mark_q;
	logic [LVL_W-1:0]  level_q;

	logic [VAL_W-1:0] sine_mem_q [STORE_DEPTH];

	// Tick update
	logic              len_hit;
	logic [LEN_W-1:0]  rem_next;
	logic [STEP_W-1:0] pend_step;
	logic              pend_flag;
	logic [STEP_W:0]   sum_old;
	logic              gate;
	logic              adopt;
	logic [STEP_W-1:0] act_next;
	logic [STEP_W-1:0] base;
	logic [STEP_W:0]   sum_adopt;
	logic [STEP_W:0]   sum_sel;
	logic [STEP_W-1:0] phase_next;
	logic [LVL_W-1:0]  level_next;
	logic [LEN_W-1:0]  attack_new;
	logic [LEN_W-1:0]  decay_new;
	logic [LEN_W-1:0]  sustain_new;

	// Pipeline
	logic [STEP_W-1:0] phase_s2;
	logic [LVL_W-1:0]  level_s2;
	logic [DEG_W-1:0]  deg_s3;
	logic [LVL_W-1:0]  level_s3;
	logic [IDX_W-1:0]  addr;
	logic              inv;
	logic [VAL_W-1:0]  rd_s4;
	logic              inv_s4;
	logic [LVL_W-1:0]  level_s4;
	logic [VAL_W-1:0]  sine_val;
	logic signed [VAL_W:0]       dev;
	logic signed [VAL_W+LVL_W+1:0] prod;
	logic signed [VAL_W+LVL_W+1:0] quot;
	logic [VAL_W-1:0]  scaled_s5;

	always_comb begin
		len_hit   = (remaining_len_q == LEN_W'(1));
		rem_next  = (remaining_len_q != '0) ? remaining_len_q - LEN_W'(1) : '0;
		pend_step = len_hit ? '0 : pending_step_q;
		pend_flag = len_hit | note_pending_q;

		sum_old = {1'b0, phase_acc_q} + {1'b0, active_step_q};
		gate    = (sum_old >= FULL_TURN) || (active_step_q == '0);
		adopt   = gate && pend_flag;

		act_next  = adopt ? pend_step : active_step_q;
		base      = (adopt && (pend_step == '0)) ? '0 : phase_acc_q;
		sum_adopt = {1'b0, base} + {1'b0, pend_step};
		sum_sel   = adopt ? sum_adopt : sum_old;
		if (sum_sel >= FULL_TURN) begin
			phase_next = STEP_W'(sum_sel - FULL_TURN);
		end else begin
			phase_next = STEP_W'(sum_sel);
		end

		attack_new  = div10(D10_IN_W'(rem_next) * D10_IN_W'(9));
		decay_new   = div10(D10_IN_W'(rem_next) * D10_IN_W'(8));
		sustain_new = div10(D10_IN_W'(rem_next));

		// On adoption the attack mark sits below any nonzero length
		if (adopt) begin
			level_next = (rem_next != '0) ? LVL_ATTACK : LVL_RELEASE;
		end else if (gate) begin
			if (rem_next > attack_mark_q) begin
				level_next = LVL_ATTACK;
			end else if (rem_next > decay_mark_q) begin
				level_next = LVL_PEAK;
			end else if (rem_next > sustain_mark_q) begin
				level_next = LVL_SUSTAIN;
			end else begin
				level_next = LVL_RELEASE;
			end
		end else begin
			level_next = level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q     <= '0;
			active_step_q   <= '0;
			pending_step_q  <= '0;
			remaining_len_q <= '0;
			note_pending_q  <= 1'b1;
			attack_mark_q   <= '0;
			decay_mark_q    <= '0;
			sustain_mark_q  <= '0;
			level_q         <= LVL_PEAK;
		end else if (ctrl.tick) begin
			phase_acc_q     <= phase_next;
			active_step_q   <= act_next;
			pending_step_q  <= pend_step;
			remaining_len_q <= rem_next;
			note_pending_q  <= adopt ? 1'b0 : pend_flag;
			level_q         <= level_next;
			if (adopt) begin
				attack_mark_q  <= attack_new;
				decay_mark_q   <= decay_new;
				sustain_mark_q <= sustain_new;
			end
		end else if (ctrl.note) begin
			pending_step_q  <= step;
			remaining_len_q <= len;
			note_pending_q  <= 1'b1;
		end
	end

	// Fold the degree onto the quarter wave
	always_comb begin
		if (deg_s3 < DEG_QUARTER) begin
			addr = IDX_W'(deg_s3);
			inv  = 1'b0;
		end else if (deg_s3 < DEG_HALF) begin
			addr = IDX_W'(DEG_HALF - deg_s3);
			inv  = 1'b0;
		end else if (deg_s3 < DEG_3QUART) begin
			addr = IDX_W'(deg_s3 - DEG_HALF);
			inv  = 1'b1;
		end else begin
			addr = IDX_W'(DEG_FULL - deg_s3);
			inv  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sine_mem_q[idx] <= val;
		end
		if (ctrl.tick) begin
			phase_s2 <= phase_next;
			level_s2 <= level_next;
		end
		if (ctrl.en_s3) begin
			deg_s3   <= div1000(phase_s2);
			level_s3 <= level_s2;
		end
		if (ctrl.en_s4) begin
			rd_s4    <= sine_mem_q[addr];
			inv_s4   <= inv;
			level_s4 <= level_s3;
		end
		if (ctrl.en_s5) begin
			scaled_s5 <= VAL_W'(quot + (VAL_W+LVL_W+2)'(MID_CODE));
		end
	end

	// Scale about mid code, truncate toward zero
	always_comb begin
		sine_val = inv_s4 ? TOP_CODE - rd_s4 : rd_s4;
		dev      = $signed({1'b0, sine_val}) - $signed({1'b0, MID_CODE});
		prod     = (VAL_W+LVL_W+2)'(dev) * $signed({1'b0, level_s4});
		if (prod < 0) begin
			quot = (prod + (VAL_W+LVL_W+2)'(15)) >>> 4;
		end else begin
			quot = prod >>> 4;
		end
	end

	assign scaled = scaled_s5;

endmodule

[hw/rtl/three_voice_sine_tone_generator.sv]
// A tick item passes the input stage, stages s2 to s5 and the output register; while
// not stalled, throughput is one item per cycle; a load rides the tick pipeline down
// to the store write, while note items and dropped items finish in the input stage.
// Note and load items give no result; a held sample backs up ticks and loads alike.
// Reset (arst_n low) clears all voice state and pipeline valids at once;
// the sine store is undefined until loaded.
module three_voice_sine_tone_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tsg_pkg::CMD_W-1:0]     cmd,
	input  logic [tsg_pkg::VOICE_W-1:0]   voice,
	input  logic [tsg_pkg::STEP_W-1:0]    phase_step,
	input  logic [tsg_pkg::LEN_W-1:0]     note_length,
	input  logic [tsg_pkg::IDX_W-1:0]     table_index,
	input  logic [tsg_pkg::VAL_W-1:0]     table_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [tsg_pkg::SAMPLE_W-1:0] sample
);
	import tsg_pkg::*;

	// Input stage: item held here while its command is decoded
	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [VOICE_W-1:0] voice_s1;
	logic [STEP_W-1:0]  step_s1;
	logic [LEN_W-1:0]   len_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [VAL_W-1:0]   val_s1;

	// Tick pipeline valids and the output register
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;
	logic out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	// Loads travel with the ticks so that store writes and reads keep item order
	logic               load_s2;
	logic               load_s3;
	logic               load_s4;
	logic               load_s5;
	logic [IDX_W-1:0]   idx_s2;
	logic [IDX_W-1:0]   idx_s3;
	logic [VAL_W-1:0]   val_s2;
	logic [VAL_W-1:0]   val_s3;

	// Flow control: a stage may take a new item when empty or draining
	logic ready_o;
	logic ready5;
	logic ready4;
	logic ready3;
	logic ready2;
	logic ready1;
	logic done1;
	logic fwd1;
	logic pass_go;
	logic is_tick;
	logic tick_go;
	logic note_go;
	logic load_go;
	logic wr_go;

	logic [VAL_W-1:0]  scaled [VOICE_COUNT];
	logic [MIX_W-1:0]  acc;
	logic [MIX_W-1:0]  mix;

	assign is_tick = (cmd_s1 == CMD_TICK);

	assign ready_o = !out_valid_q || !out_stall;
	assign ready5  = !valid_s5 || ready_o;
	assign ready4  = !valid_s4 || ready5;
	assign ready3  = !valid_s3 || ready4;
	assign ready2  = !valid_s2 || ready3;

	// Ticks and in-range loads need room downstream; everything else retires here.
	// Drop loads beyond the end of the store
	assign fwd1   = is_tick || ((cmd_s1 == CMD_LOAD) && (32'(idx_s1) < STORE_DEPTH));
	assign done1  = valid_s1 && (!fwd1 || ready2);
	assign ready1 = !valid_s1 || done1;

	assign pass_go = valid_s1 && fwd1 && ready2;
	assign tick_go = pass_go && is_tick;
	assign note_go = done1 && (cmd_s1 == CMD_NOTE);
	assign load_go = pass_go && !is_tick;
	// Write the store at the edge where a tick in the same stage would read it
	assign wr_go   = valid_s3 && load_s3 && ready4;

	assign in_stall = !ready1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready1) valid_s1 <= in_valid;
			if (ready2) valid_s2 <= pass_go;
			if (ready3) valid_s3 <= valid_s2;
			if (ready4) valid_s4 <= valid_s3;
			if (ready5) valid_s5 <= valid_s4;
			if (ready_o) out_valid_q <= valid_s5 && !load_s5;
		end
	end

	// Capture the item; saturate step and store word on the way in
	always_ff @(posedge clk) begin
		if (ready1) begin
			cmd_s1   <= cmd_t'(cmd);
			voice_s1 <= voice;
			step_s1  <= (phase_step > STEP_MAX) ? STEP_MAX : phase_step;
			len_s1   <= note_length;
			idx_s1   <= table_index;
			val_s1   <= (table_value > TOP_CODE) ? TOP_CODE : table_value;
		end
		if (ready2) begin
			load_s2 <= load_go;
			idx_s2  <= idx_s1;
			val_s2  <= val_s1;
		end
		if (ready3) begin
			load_s3 <= load_s2;
			idx_s3  <= idx_s2;
			val_s3  <= val_s2;
		end
		if (ready4) load_s4 <= load_s3;
		if (ready5) load_s5 <= load_s4;
		if (valid_s5 && !load_s5 && ready_o) begin
			sample_q <= SAMPLE_W'(mix);
		end
	end

	// One lane per voice; every lane keeps its own copy of the sine store
	for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_voice
		voice_ctrl_t ctrl;

		always_comb begin
			ctrl.tick  = tick_go;
			// Ignore notes aimed at a voice that does not exist
			ctrl.note  = note_go && (32'(voice_s1) == g);
			ctrl.load  = wr_go;
			ctrl.en_s3 = valid_s2 && ready3;
			ctrl.en_s4 = valid_s3 && ready4;
			ctrl.en_s5 = valid_s4 && ready5;
		end

		tsg_voice u_voice (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.step   (step_s1),
			.len    (len_s1),
			.idx    (idx_s3),
			.val    (val_s3),
			.scaled (scaled[g])
		);
	end

	// Mix: sum of voices, doubled, shifted down by the fixed offset
	always_comb begin
		acc = '0;
		for (int k = 0; k < VOICE_COUNT; k++) begin
			acc = acc + MIX_W'(scaled[k]);
		end
		mix = (acc << 1) - MIX_OFFSET;
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule

[hw/rtl/tsg_checker.sv]
module tsg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall
);

	// Reset empties the pipeline and opens the input side
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> (!out_valid && !in_stall))
		else $error("pipeline not idle during reset");

	// Input backs up only when every stage is full and the output is held
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output side could drain");

	// A held sample stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("sample dropped while stalled");

	// With no sample waiting the input never backs up
	a_no_stall_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid) |-> !in_stall)
		else $error("input stalled with no sample waiting");

endmodule

bind three_voice_sine_tone_generator tsg_checker u_chk (.*);
